/* src/tile_gid_to_draw_rect_assert.svh */
// assertion macros for the tile resolver
`ifndef TILE_GID_TO_DRAW_RECT_ASSERT_SVH
`define TILE_GID_TO_DRAW_RECT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define TGD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define TGD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/tgd_pkg.sv */
package tgd_pkg;

  localparam int unsigned TilesetSlotsDef = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegMapTileW  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMapTileH  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCameraX   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCameraY   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCameraW   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCameraH   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLayerCols = 3'd6;
  localparam logic [CfgIdxW-1:0] RegLayerRows = 3'd7;

  localparam logic [1:0] StDrawn   = 2'd0;
  localparam logic [1:0] StOutside = 2'd1;
  localparam logic [1:0] StEmpty   = 2'd2;
  localparam logic [1:0] StNoMatch = 2'd3;

  localparam logic ActLoad    = 1'b0;
  localparam logic ActResolve = 1'b1;

  typedef struct packed {
    logic        action;
    logic [2:0]  slot;
    logic [28:0] first_id;
    logic [15:0] id_count;
    logic [10:0] sheet_columns;
    logic [10:0] sheet_tile_width;
    logic [10:0] sheet_tile_height;
    logic [11:0] cell_row;
    logic [11:0] cell_column;
    logic [31:0] raw_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  tileset_slot;
    logic [19:0] source_x;
    logic [25:0] source_y;
    logic [10:0] source_width;
    logic [10:0] source_height;
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SPAN, S_LOOK, S_DIV, S_MUL, S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic span_start;
    logic look_step;
    logic div_start;
    logic mul_step;
    logic out_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic span_done;
    logic look_done;
    logic early_result;
    logic div_done;
  } stat_t;

endpackage

/* src/tgd_div.sv */
// restoring divider, one quotient bit per cycle
module tgd_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [W:0] trial;

  // load on start, otherwise one shift and subtract step while busy
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = !busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

/* src/tgd_datapath.sv */
`include "tile_gid_to_draw_rect_assert.svh"
// table, window test, slot search, divide and multiply datapath
module tgd_datapath #(
  parameter int unsigned TilesetSlots = tgd_pkg::TilesetSlotsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tgd_pkg::in_item_t        item_i,
  input  logic                     cfg_we_i,
  input  logic [tgd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tgd_pkg::CfgDataW-1:0] cfg_data_i,
  input  tgd_pkg::ctrl_t           ctrl_i,
  output tgd_pkg::stat_t           stat_o,
  output tgd_pkg::out_item_t       result_o
);
  localparam int unsigned SlotW = (TilesetSlots > 1) ? $clog2(TilesetSlots) : 1;
  localparam int unsigned SlotCntW = $clog2(TilesetSlots + 1);

  // configuration registers
  logic [10:0] mtw_q, mth_q;
  logic signed [15:0] cam_x_q, cam_y_q;
  logic [13:0] cam_w_q, cam_h_q;
  logic [12:0] cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtw_q   <= 11'd16;
      mth_q   <= 11'd16;
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_w_q <= 14'd640;
      cam_h_q <= 14'd480;
      cols_q  <= 13'd64;
      rows_q  <= 13'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tgd_pkg::RegMapTileW:  mtw_q   <= cfg_data_i[10:0];
        tgd_pkg::RegMapTileH:  mth_q   <= cfg_data_i[10:0];
        tgd_pkg::RegCameraX:   cam_x_q <= cfg_data_i;
        tgd_pkg::RegCameraY:   cam_y_q <= cfg_data_i;
        tgd_pkg::RegCameraW:   cam_w_q <= cfg_data_i[13:0];
        tgd_pkg::RegCameraH:   cam_h_q <= cfg_data_i[13:0];
        tgd_pkg::RegLayerCols: cols_q  <= cfg_data_i[12:0];
        tgd_pkg::RegLayerRows: rows_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // tileset table
  logic [TilesetSlots-1:0] ent_valid_q;
  logic [28:0] ent_first_q [TilesetSlots];
  logic [15:0] ent_count_q [TilesetSlots];
  logic [10:0] ent_cols_q  [TilesetSlots];
  logic [10:0] ent_tw_q    [TilesetSlots];
  logic [10:0] ent_th_q    [TilesetSlots];
  logic load_ok;
  logic load_hit;
  logic [SlotW-1:0] ld_idx;

  assign ld_idx = SlotW'(item_i.slot);
  assign load_hit = ctrl_i.capture && (item_i.action == tgd_pkg::ActLoad) &&
                    (32'(item_i.slot) < TilesetSlots);
  assign load_ok = (item_i.first_id != '0) && (item_i.id_count != '0) &&
                   (item_i.sheet_columns != '0) && (item_i.sheet_tile_width != '0) &&
                   (item_i.sheet_tile_height != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else if (load_hit) begin
      ent_valid_q[ld_idx] <= load_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      ent_first_q[ld_idx] <= item_i.first_id;
      ent_count_q[ld_idx] <= item_i.id_count;
      ent_cols_q[ld_idx]  <= item_i.sheet_columns;
      ent_tw_q[ld_idx]    <= item_i.sheet_tile_width;
      ent_th_q[ld_idx]    <= item_i.sheet_tile_height;
    end
  end

  // captured resolve item
  logic [11:0] row_q, col_q;
  logic [28:0] gid_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      row_q <= item_i.cell_row;
      col_q <= item_i.cell_column;
      gid_q <= item_i.raw_id[28:0];
    end
  end

  // window test: x and y camera edges divided by map tile size
  logic [10:0] tw_eff, th_eff;
  assign tw_eff = (mtw_q == '0) ? 11'd1 : mtw_q;
  assign th_eff = (mth_q == '0) ? 11'd1 : mth_q;

  // signed truncating division done on magnitudes, one divider per edge
  logic signed [17:0] ex_x, ex_y;
  assign ex_x = 18'(cam_x_q) + 18'($signed({1'b0, cam_w_q}));
  assign ex_y = 18'(cam_y_q) + 18'($signed({1'b0, cam_h_q}));

  logic [17:0] dn [4];
  logic [3:0]  dneg;
  logic [17:0] dq [4];
  logic [17:0] drm [4];
  logic [3:0]  ddone;
  logic [3:0]  neg_q;

  always_comb begin
    dneg[0] = cam_x_q[15];
    dneg[1] = ex_x[17];
    dneg[2] = cam_y_q[15];
    dneg[3] = ex_y[17];
    dn[0] = dneg[0] ? 18'(-18'(cam_x_q)) : 18'(cam_x_q);
    dn[1] = dneg[1] ? 18'(-ex_x) : ex_x;
    dn[2] = dneg[2] ? 18'(-18'(cam_y_q)) : 18'(cam_y_q);
    dn[3] = dneg[3] ? 18'(-ex_y) : ex_y;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.span_start) neg_q <= dneg;
  end

  for (genvar g = 0; g < 4; g++) begin : g_span_div
    tgd_div #(.W(18)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (ctrl_i.span_start),
      .num_i   (dn[g]),
      .den_i   ({7'd0, (g < 2) ? tw_eff : th_eff}),
      .done_o  (ddone[g]),
      .quo_o   (dq[g]),
      .rem_o   (drm[g])
    );
  end

  logic signed [18:0] sq [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sq[k] = neg_q[k] ? -$signed({1'b0, dq[k]}) : $signed({1'b0, dq[k]});
    end
  end

  logic in_x, in_y;
  always_comb begin
    logic signed [19:0] st, en;
    st = (sq[0] < 0) ? 20'sd0 : 20'(sq[0]);
    en = 20'(sq[1]) + 20'sd1;
    if (en > $signed({7'd0, cols_q})) en = $signed({7'd0, cols_q});
    in_x = ($signed({8'd0, col_q}) >= st) && ($signed({8'd0, col_q}) < en);
    st = (sq[2] < 0) ? 20'sd0 : 20'(sq[2]);
    en = 20'(sq[3]) + 20'sd1;
    if (en > $signed({7'd0, rows_q})) en = $signed({7'd0, rows_q});
    in_y = ($signed({8'd0, row_q}) >= st) && ($signed({8'd0, row_q}) < en);
  end

  // slot search, one slot per cycle
  logic [SlotCntW-1:0] scan_q;
  logic found_q;
  logic [SlotW-1:0] best_q;
  logic [SlotW-1:0] scan_idx;
  logic hit;
  assign scan_idx = scan_q[SlotW-1:0];
  assign hit = ent_valid_q[scan_idx] && (gid_q >= ent_first_q[scan_idx]) &&
               ((gid_q - ent_first_q[scan_idx]) < 29'(ent_count_q[scan_idx]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      found_q <= 1'b0;
      best_q  <= '0;
    end else if (ctrl_i.span_start) begin
      scan_q  <= '0;
      found_q <= 1'b0;
    end else if (ctrl_i.look_step && (scan_q != SlotCntW'(TilesetSlots))) begin
      if (hit && (!found_q || (ent_first_q[scan_idx] > ent_first_q[best_q]))) begin
        best_q  <= scan_idx;
        found_q <= 1'b1;
      end
      scan_q <= scan_q + 1'b1;
    end
  end

  // local id split by sheet columns
  logic [28:0] lq, lr;
  logic ldone;
  logic [28:0] local_id;
  assign local_id = gid_q - ent_first_q[best_q];
  tgd_div #(.W(29)) u_local_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.div_start),
    .num_i   (local_id),
    .den_i   ({18'd0, ent_cols_q[best_q]}),
    .done_o  (ldone),
    .quo_o   (lq),
    .rem_o   (lr)
  );

  // products, registered
  logic [19:0] sx_q;
  logic [25:0] sy_q;
  logic [23:0] scx_q, scy_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_step) begin
      sx_q  <= 20'(lr * 29'(ent_tw_q[best_q]));
      sy_q  <= 26'(lq * 29'(ent_th_q[best_q]));
      scx_q <= 24'(24'(col_q) * 24'(tw_eff) - 24'(cam_x_q));
      scy_q <= 24'(24'(row_q) * 24'(th_eff) - 24'(cam_y_q));
    end
  end

  // result selection
  logic outside, empty;
  tgd_pkg::out_item_t res_d;
  assign outside = !(in_x && in_y);
  assign empty = (gid_q == '0);
  always_comb begin
    res_d = '0;
    if (outside) res_d.status = tgd_pkg::StOutside;
    else if (empty) res_d.status = tgd_pkg::StEmpty;
    else if (!found_q) res_d.status = tgd_pkg::StNoMatch;
    else begin
      res_d.status        = tgd_pkg::StDrawn;
      res_d.tileset_slot  = 3'(best_q);
      res_d.source_x      = sx_q;
      res_d.source_y      = sy_q;
      res_d.source_width  = ent_tw_q[best_q];
      res_d.source_height = ent_th_q[best_q];
      res_d.screen_x      = scx_q;
      res_d.screen_y      = scy_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) result_o <= res_d;
  end

  assign stat_o.span_done    = &ddone;
  assign stat_o.look_done    = (scan_q == SlotCntW'(TilesetSlots));
  assign stat_o.early_result = outside || empty || !found_q;
  assign stat_o.div_done     = ldone;

  `TGD_ASSERT_NEXT(a_scan_restart, clk_i, rst_ni, ctrl_i.span_start, scan_q == '0,
    "slot scan did not restart")
  `TGD_ASSERT_IMP(a_best_valid, clk_i, rst_ni, found_q && ctrl_i.look_step,
    ent_valid_q[best_q], "winning slot is not valid")
  `TGD_ASSERT_IMP(a_scan_bound, clk_i, rst_ni, 1'b1,
    scan_q <= SlotCntW'(TilesetSlots), "slot scan ran past the table")
endmodule

/* src/tgd_ctrl.sv */
`include "tile_gid_to_draw_rect_assert.svh"
// sequencer for one item at a time
module tgd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_action_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tgd_pkg::ctrl_t ctrl_o,
  input  tgd_pkg::stat_t stat_i
);
  tgd_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o = (state_q == tgd_pkg::S_IDLE);
  assign accept = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tgd_pkg::S_IDLE:
        if (accept && in_action_i == tgd_pkg::ActResolve) state_d = tgd_pkg::S_SPAN;
      tgd_pkg::S_SPAN: state_d = tgd_pkg::S_LOOK;
      tgd_pkg::S_LOOK:
        if (stat_i.span_done && stat_i.look_done) begin
          state_d = stat_i.early_result ? tgd_pkg::S_OUT : tgd_pkg::S_DIV;
        end
      tgd_pkg::S_DIV:
        if (stat_i.div_done && !ctrl_o.div_start) state_d = tgd_pkg::S_MUL;
      tgd_pkg::S_MUL: state_d = tgd_pkg::S_OUT;
      tgd_pkg::S_OUT:
        if (!out_valid_q || out_ready_i) state_d = tgd_pkg::S_IDLE;
      default: state_d = tgd_pkg::S_IDLE;
    endcase
  end

  // outputs
  logic div_started_q;
  always_comb begin
    ctrl_o = '0;
    ctrl_o.capture = accept;
    case (state_q)
      tgd_pkg::S_SPAN: ctrl_o.span_start = 1'b1;
      tgd_pkg::S_LOOK: ctrl_o.look_step = 1'b1;
      tgd_pkg::S_DIV:  ctrl_o.div_start = !div_started_q;
      tgd_pkg::S_MUL:  ctrl_o.mul_step = 1'b1;
      tgd_pkg::S_OUT:  ctrl_o.out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (ctrl_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tgd_pkg::S_IDLE;
      out_valid_q   <= 1'b0;
      div_started_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      div_started_q <= (state_q == tgd_pkg::S_DIV);
    end
  end

  assign out_valid_o = out_valid_q;

  `TGD_ASSERT_NEXT(a_load_result, clk_i, rst_ni, ctrl_o.out_load, out_valid_o,
    "loaded item not shown")
  `TGD_ASSERT_IMP(a_idle_only, clk_i, rst_ni, ctrl_o.capture,
    state_q == tgd_pkg::S_IDLE, "item taken while busy")
  `TGD_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i && !ctrl_o.out_load,
    out_valid_o, "pending item dropped")
endmodule

/* src/tile_gid_to_draw_rect.sv */
// sequence: a load item writes the table when it is taken; a resolve item is taken, then
//   starts the window dividers and restarts the slot scan, waits for both, and, when a
//   tileset matches, runs the local id divider and the multiply before the output register
// flow: one item at a time; after a resolve item the input is not ready again until its
//   result is loaded, which waits while the receiver holds back the previous result
// reset: configuration registers return to their defaults, all tileset slots become invalid
module tile_gid_to_draw_rect #(
  parameter int unsigned TilesetSlots = tgd_pkg::TilesetSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tgd_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tgd_pkg::out_item_t           out_item_o,
  input  logic                         cfg_we_i,
  input  logic [tgd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tgd_pkg::CfgDataW-1:0] cfg_data_i
);
  tgd_pkg::ctrl_t ctrl;
  tgd_pkg::stat_t stat;

  tgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_item_i.action),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  tgd_datapath #(.TilesetSlots(TilesetSlots)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .result_o   (out_item_o)
  );
endmodule

/* tb/tile_gid_to_draw_rect_tb.sv */
module tile_gid_to_draw_rect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots = int'(tgd_pkg::TilesetSlotsDef);
  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  tgd_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  tgd_pkg::out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [tgd_pkg::CfgIdxW-1:0] cfg_idx_i = tgd_pkg::RegMapTileW;
  logic [tgd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  tile_gid_to_draw_rect u_top (.*);

  always #2 clk_i = ~clk_i;

  // predictor copy of registers and tileset table
  int unsigned mtw, mth, cam_w, cam_h, lay_cols, lay_rows;
  int cam_x, cam_y;
  bit          ts_valid [NumSlots];
  logic [28:0] ts_first [NumSlots];
  logic [15:0] ts_count [NumSlots];
  logic [10:0] ts_cols [NumSlots];
  logic [10:0] ts_tw [NumSlots];
  logic [10:0] ts_th [NumSlots];

  tgd_pkg::out_item_t draw_q[$];
  int errors = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  int idle_cycles = 0;

  // sender gaps and directed table
  typedef struct {
    tgd_pkg::in_item_t item;
    bit       typed;
    tgd_pkg::out_item_t want;
  } dir_row_t;

  function automatic bit cell_visible(int cam, int unsigned ext, int unsigned tile,
                                      int unsigned cells, int unsigned idx);
    int t;
    int lo;
    int hi;
    t = (tile == 0) ? 1 : int'(tile);
    lo = cam / t;
    hi = (cam + int'(ext)) / t + 1;
    if (lo < 0) lo = 0;
    if (hi > int'(cells)) hi = int'(cells);
    return (int'(idx) >= lo) && (int'(idx) < hi);
  endfunction

  // apply an item to the table and return the draw command it produces
  function automatic bit resolve_cell(tgd_pkg::in_item_t it, output tgd_pkg::out_item_t r);
    logic [31:0] gid;
    int best;
    longint unsigned loc, cols, m;
    r = '0;
    if (it.action == tgd_pkg::ActLoad) begin
      ts_first[it.slot] = it.first_id;
      ts_count[it.slot] = it.id_count;
      ts_cols[it.slot] = it.sheet_columns;
      ts_tw[it.slot] = it.sheet_tile_width;
      ts_th[it.slot] = it.sheet_tile_height;
      ts_valid[it.slot] = (it.first_id != 0) && (it.id_count != 0) &&
        (it.sheet_columns != 0) && (it.sheet_tile_width != 0) &&
        (it.sheet_tile_height != 0);
      return 1'b0;
    end
    if (!cell_visible(cam_x, cam_w, mtw, lay_cols, it.cell_column) ||
        !cell_visible(cam_y, cam_h, mth, lay_rows, it.cell_row)) begin
      r.status = tgd_pkg::StOutside;
      return 1'b1;
    end
    gid = {3'b000, it.raw_id[28:0]};
    if (gid == 0) begin
      r.status = tgd_pkg::StEmpty;
      return 1'b1;
    end
    best = -1;
    for (int i = 0; i < NumSlots; i++) begin
      if (!ts_valid[i] || gid < ts_first[i]) continue;
      if (gid - ts_first[i] >= ts_count[i]) continue;
      if (best < 0 || ts_first[i] > ts_first[best]) best = i;
    end
    if (best < 0) begin
      r.status = tgd_pkg::StNoMatch;
      return 1'b1;
    end
    loc = gid - ts_first[best];
    cols = (ts_cols[best] == 0) ? 1 : ts_cols[best];
    r.status = tgd_pkg::StDrawn;
    r.tileset_slot = 3'(best);
    r.source_x = 20'((loc % cols) * ts_tw[best]);
    r.source_y = 26'((loc / cols) * ts_th[best]);
    r.source_width = ts_tw[best];
    r.source_height = ts_th[best];
    m = (mtw == 0) ? 1 : mtw;
    r.screen_x = 24'(longint'(it.cell_column * m) - longint'(cam_x));
    m = (mth == 0) ? 1 : mth;
    r.screen_y = 24'(longint'(it.cell_row * m) - longint'(cam_y));
    return 1'b1;
  endfunction

  // register write, block idle
  task automatic write_reg(logic [tgd_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tgd_pkg::RegMapTileW:  mtw = 32'(val[10:0]);
      tgd_pkg::RegMapTileH:  mth = 32'(val[10:0]);
      tgd_pkg::RegCameraX:   cam_x = int'($signed(val));
      tgd_pkg::RegCameraY:   cam_y = int'($signed(val));
      tgd_pkg::RegCameraW:   cam_w = 32'(val[13:0]);
      tgd_pkg::RegCameraH:   cam_h = 32'(val[13:0]);
      tgd_pkg::RegLayerCols: lay_cols = 32'(val[12:0]);
      default:               lay_rows = 32'(val[12:0]);
    endcase
  endtask

  // sender idle until every expected result has come
  task automatic drain;
    in_valid_i <= 1'b0;
    while (draw_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // called at a falling edge; valid stays up until the next item or gap decides
  task automatic send_item(tgd_pkg::in_item_t it);
    tgd_pkg::out_item_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (resolve_cell(it, r)) draw_q = {draw_q, r};
    @(negedge clk_i);
  endtask

  function automatic tgd_pkg::in_item_t load_item(int s, logic [28:0] f, logic [15:0] c,
                                                  logic [10:0] sc, logic [10:0] w,
                                                  logic [10:0] h);
    tgd_pkg::in_item_t it;
    it = '0;
    it.action = tgd_pkg::ActLoad;
    it.slot = 3'(s);
    it.first_id = f;
    it.id_count = c;
    it.sheet_columns = sc;
    it.sheet_tile_width = w;
    it.sheet_tile_height = h;
    it.raw_id = $urandom;
    it.cell_row = 12'($urandom);
    it.cell_column = 12'($urandom);
    return it;
  endfunction

  function automatic tgd_pkg::in_item_t cell_item(logic [11:0] r, logic [11:0] c,
                                                  logic [31:0] raw);
    tgd_pkg::in_item_t it;
    it = '0;
    it.action = tgd_pkg::ActResolve;
    it.slot = 3'($urandom);
    it.first_id = 29'($urandom);
    it.id_count = 16'($urandom);
    it.sheet_columns = 11'($urandom);
    it.sheet_tile_width = 11'($urandom);
    it.sheet_tile_height = 11'($urandom);
    it.cell_row = r;
    it.cell_column = c;
    it.raw_id = raw;
    return it;
  endfunction

  function automatic tgd_pkg::in_item_t rand_item();
    tgd_pkg::in_item_t it;
    int s;
    if ($urandom_range(3) == 0) begin
      s = int'($urandom_range(NumSlots - 1));
      it = load_item(s, $urandom_range(3) == 0 ? 29'($urandom) : 29'($urandom_range(1, 600)),
                     $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 200)),
                     $urandom_range(9) == 0 ? 11'($urandom) : 11'($urandom_range(1, 16)),
                     11'($urandom_range(1, 2047)), 11'($urandom_range(1, 2047)));
      if ($urandom_range(15) == 0) it.sheet_tile_height = 0;
    end else begin
      it = cell_item($urandom_range(5) == 0 ? 12'($urandom) : 12'($urandom_range(0, 70)),
                     $urandom_range(5) == 0 ? 12'($urandom) : 12'($urandom_range(0, 70)),
                     {3'($urandom), $urandom_range(3) == 0 ? 29'($urandom) :
                      29'($urandom_range(0, 700))});
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    tgd_pkg::out_item_t w;
    if (out_valid_o && out_ready_i) begin
      if (draw_q.size() == 0) begin
        $error("unexpected result %p", out_item_o);
        errors++;
      end else begin
        w = draw_q.pop_front();
        if (out_item_o.status !== w.status) begin
          $error("status exp %0d got %0d", w.status, out_item_o.status); errors++;
        end
        if (out_item_o.tileset_slot !== w.tileset_slot) begin
          $error("tileset_slot exp %0d got %0d", w.tileset_slot, out_item_o.tileset_slot);
          errors++;
        end
        if (out_item_o.source_x !== w.source_x) begin
          $error("source_x exp %0d got %0d", w.source_x, out_item_o.source_x); errors++;
        end
        if (out_item_o.source_y !== w.source_y) begin
          $error("source_y exp %0d got %0d", w.source_y, out_item_o.source_y); errors++;
        end
        if (out_item_o.source_width !== w.source_width) begin
          $error("source_width exp %0d got %0d", w.source_width, out_item_o.source_width);
          errors++;
        end
        if (out_item_o.source_height !== w.source_height) begin
          $error("source_height exp %0d got %0d", w.source_height, out_item_o.source_height);
          errors++;
        end
        if (out_item_o.screen_x !== w.screen_x) begin
          $error("screen_x exp %0d got %0d", w.screen_x, out_item_o.screen_x); errors++;
        end
        if (out_item_o.screen_y !== w.screen_y) begin
          $error("screen_y exp %0d got %0d", w.screen_y, out_item_o.screen_y); errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on accepted items and taken results
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t d;
    int pg[4];
    int ps[4];
    mtw = 16; mth = 16; cam_x = 0; cam_y = 0; cam_w = 640; cam_h = 480;
    lay_cols = 64; lay_rows = 64;
    foreach (ts_valid[i]) ts_valid[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, flags, outside, extremes, priorities, invalid load
    d.want = '0;
    d.typed = 1; d.item = cell_item(0, 0, 32'h1); d.want.status = tgd_pkg::StNoMatch;
    rows = {rows, d};
    d.item = cell_item(0, 0, 32'hE000_0000); d.want.status = tgd_pkg::StEmpty;
    rows = {rows, d};
    d.item = cell_item(12'hFFF, 0, 32'h5); d.want.status = tgd_pkg::StOutside;
    rows = {rows, d};
    d.item = cell_item(0, 12'hFFF, 32'h5); rows = {rows, d};
    d.typed = 0;
    d.item = load_item(0, 1, 16'hFFFF, 11'd1024, 11'd1024, 11'd1024); rows = {rows, d};
    d.item = load_item(1, 10, 5, 2, 8, 8); rows = {rows, d};
    d.item = load_item(2, 10, 5, 3, 4, 4); rows = {rows, d};
    d.item = load_item(7, 29'h1FFF_FFFF, 1, 11'h7FF, 11'h7FF, 11'h7FF); rows = {rows, d};
    d.item = cell_item(0, 0, 32'h1); rows = {rows, d};
    d.item = cell_item(3, 5, 32'hE000_000C); rows = {rows, d};
    d.item = cell_item(29, 39, 32'h1000_FFFF); rows = {rows, d};
    d.item = cell_item(30, 40, 32'h1FFF_FFFF); rows = {rows, d};
    d.item = cell_item(63, 63, 32'h1FFF_FFFF); rows = {rows, d};
    d.item = load_item(7, 29'h1FFF_FFFF, 0, 1, 1, 1); rows = {rows, d};
    d.item = cell_item(1, 1, 32'h3FFF_FFFF); rows = {rows, d};
    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].typed && rows[i].want != draw_q[$]) begin
        $error("table row %0d exp %p model %p", i, rows[i].want, draw_q[$]);
        errors++;
      end
    end
    drain();

    pg = '{0, 60, 0, 25};
    ps = '{0, 0, 60, 25};
    for (int ph = 0; ph < 4; ph++) begin
      // new register setting per phase, extremes included
      case (ph)
        0: begin
          write_reg(tgd_pkg::RegMapTileW, 1); write_reg(tgd_pkg::RegMapTileH, 1024);
          write_reg(tgd_pkg::RegCameraX, 16'h8000); write_reg(tgd_pkg::RegCameraY, 16'h7FFF);
          write_reg(tgd_pkg::RegCameraW, 8192); write_reg(tgd_pkg::RegCameraH, 1);
          write_reg(tgd_pkg::RegLayerCols, 4096); write_reg(tgd_pkg::RegLayerRows, 1);
        end
        1: begin
          write_reg(tgd_pkg::RegMapTileW, 1024); write_reg(tgd_pkg::RegMapTileH, 0);
          write_reg(tgd_pkg::RegCameraX, 16'h7FFF); write_reg(tgd_pkg::RegCameraY, 16'h8000);
          write_reg(tgd_pkg::RegCameraW, 1); write_reg(tgd_pkg::RegCameraH, 8192);
          write_reg(tgd_pkg::RegLayerCols, 1); write_reg(tgd_pkg::RegLayerRows, 4096);
        end
        default: begin
          write_reg(tgd_pkg::RegMapTileW, 16'($urandom_range(1, 40)));
          write_reg(tgd_pkg::RegMapTileH, 16'($urandom_range(1, 40)));
          write_reg(tgd_pkg::RegCameraX, 16'($urandom_range(0, 300) - 150));
          write_reg(tgd_pkg::RegCameraY, 16'($urandom_range(0, 300) - 150));
          write_reg(tgd_pkg::RegCameraW, 16'($urandom_range(100, 2000)));
          write_reg(tgd_pkg::RegCameraH, 16'($urandom_range(100, 2000)));
          write_reg(tgd_pkg::RegLayerCols, 16'($urandom_range(1, 80)));
          write_reg(tgd_pkg::RegLayerRows, 16'($urandom_range(1, 80)));
        end
      endcase
      gap_pct = pg[ph];
      stall_pct = ps[ph];
      for (int n = 0; n < 110; n++) begin
        send_item(rand_item());
        if (n == 55) drain();
      end
      drain();
    end
    stall_pct = 0;
    drain();
    if (errors == 0 && draw_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/tgd_pkg.sv
src/tgd_div.sv
src/tgd_datapath.sv
src/tgd_ctrl.sv
src/tile_gid_to_draw_rect.sv
tb/tile_gid_to_draw_rect_tb.sv
